@@ rtl/core/cht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, sizes and codes of the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

  // table geometry
  localparam int BUCKETS = 7;
  localparam int RECORDS = 256;

  // field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;

  // derived widths
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W  = $clog2(RECORDS);
  localparam int LINK_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(RECORDS + 1);

  // radix-4 remainder unit: two key bits a step
  localparam int KEY_PAD    = KEY_W + (KEY_W % 2);
  localparam int HASH_STEPS = KEY_PAD / 2;
  localparam int HCNT_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  // end-of-chain link: top bit set
  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_FETCH,
    S_CHECK,
    S_LINK
  } state_t;

  // bucket result of the remainder unit
  typedef struct packed {
    logic             valid;
    logic [BKT_W-1:0] bucket;
  } hash_res_t;

  // record store request: one address, per-field write enables
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic              we_key;
    logic              we_data;
    logic              we_link;
    logic              we_live;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [LINK_W-1:0] link;
    logic              live;
  } store_req_t;

  // record store read data
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] link;
    logic              live;
  } store_rsp_t;

  // low bits of a record index as a result position
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[POS_W-1:0];
  endfunction

endpackage

@@ rtl/core/cht_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_hash
// Iterative key mod BUCKETS: takes two key bits per cycle, msb first.
// ----------------------------------------------------------------------------
module cht_hash
  import cht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [KEY_W-1:0] key,
  output hash_res_t        res
);

  localparam int T_W = BKT_W + 2;
  localparam logic [T_W-1:0] B1 = T_W'(BUCKETS);
  localparam logic [T_W-1:0] B2 = T_W'(2 * BUCKETS);
  localparam logic [T_W-1:0] B3 = T_W'(3 * BUCKETS);
  localparam logic [HCNT_W-1:0] LAST = HCNT_W'(HASH_STEPS - 1);

  logic [KEY_PAD-1:0] shreg;
  logic [BKT_W-1:0]   rem;
  logic [HCNT_W-1:0]  cnt;
  logic               run;
  logic               valid;
  logic [T_W-1:0]     t;
  logic [T_W-1:0]     t_red;

  // one radix-4 remainder step
  always_comb begin
    t = {rem, shreg[KEY_PAD-1 -: 2]};
    if (t >= B3) begin
      t_red = t - B3;
    end else if (t >= B2) begin
      t_red = t - B2;
    end else if (t >= B1) begin
      t_red = t - B1;
    end else begin
      t_red = t;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load) begin
      run   <= 1'b1;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (run) begin
      cnt   <= cnt + HCNT_W'(1);
      run   <= (cnt != LAST);
      valid <= (cnt == LAST);
    end else begin
      valid <= 1'b0;
    end
  end

  // shift register and remainder
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= KEY_PAD'(key);
      rem   <= '0;
    end else if (run) begin
      shreg <= {shreg[KEY_PAD-3:0], 2'b00};
      rem   <= t_red[BKT_W-1:0];
    end
  end

  assign res.valid  = valid;
  assign res.bucket = rem;

endmodule

@@ rtl/core/cht_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_store
// Record store: key, data, link and live arrays on one shared address.
// ----------------------------------------------------------------------------
module cht_store
  import cht_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic [KEY_W-1:0]  key_mem  [RECORDS];
  logic [DATA_W-1:0] data_mem [RECORDS];
  logic [LINK_W-1:0] link_mem [RECORDS];
  logic              live_mem [RECORDS];

  // per-field writes
  always_ff @(posedge clk) begin
    if (req.we_key) begin
      key_mem[req.addr] <= req.key;
    end
    if (req.we_data) begin
      data_mem[req.addr] <= req.data;
    end
    if (req.we_link) begin
      link_mem[req.addr] <= req.link;
    end
    if (req.we_live) begin
      live_mem[req.addr] <= req.live;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.key  <= key_mem[req.addr];
      rsp.link <= link_mem[req.addr];
      rsp.live <= live_mem[req.addr];
    end
  end

endmodule

@@ rtl/core/chained_hash_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Separate-chaining hash table: search, insert and delete over a record store.
// ----------------------------------------------------------------------------
// sequence: S_HASH until the remainder unit is done, then S_FETCH and S_CHECK
//   per chain record, S_LINK to append a record; a bad op answers from S_IDLE
// items: one at a time; the bucket remainder comes from the radix-4 unit and
//   the chain walk does one store read per record, issued in S_FETCH
// reset: bucket heads go empty and the record count to zero; store not cleared
// results come out on a one-cycle done strobe and cannot be stalled
module chained_hash_table_engine
  import cht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  input  logic [DATA_W-1:0]   payload,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [POS_W-1:0]    position
);

  localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(RECORDS);

  state_t              state, state_next;
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [DATA_W-1:0]   payload_r;
  logic [BKT_W-1:0]    bucket_r, bucket_r_next;
  logic [LINK_W-1:0]   idx, idx_next;
  logic [LINK_W-1:0]   tail, tail_next;
  logic [LINK_W-1:0]   freed, freed_next;
  logic [CNT_W-1:0]    steps, steps_next;
  logic [CNT_W-1:0]    used, used_next;
  logic [LINK_W-1:0]   head [BUCKETS];
  logic                head_we;
  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [POS_W-1:0]    position_next;
  logic                accept;
  logic                hash_load;
  logic                match;
  logic [IDX_W-1:0]    n_idx;
  hash_res_t           hres;
  store_req_t          req;
  store_rsp_t          rsp;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign hash_load = accept && (op == OP_SEARCH || op == OP_INSERT || op == OP_DELETE);
  assign n_idx     = used[IDX_W-1:0];
  assign match     = rsp.live && (rsp.key == key_r);

  cht_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .load (hash_load),
    .key  (key),
    .res  (hres)
  );

  cht_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= done_next;
    end
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) begin
        head[i] <= LINK_NONE;
      end
    end else if (head_we) begin
      head[bucket_r] <= {1'b0, n_idx};
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op;
      key_r     <= key;
      payload_r <= payload;
    end
    bucket_r <= bucket_r_next;
    idx      <= idx_next;
    tail     <= tail_next;
    freed    <= freed_next;
    steps    <= steps_next;
    status   <= status_next;
    position <= position_next;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    bucket_r_next = bucket_r;
    idx_next      = idx;
    tail_next     = tail;
    freed_next    = freed;
    steps_next    = steps;
    used_next     = used;
    head_we       = 1'b0;
    done_next     = 1'b0;
    status_next   = status;
    position_next = position;
    req           = '0;
    req.addr      = idx[IDX_W-1:0];
    req.key       = key_r;
    req.data      = payload_r;
    req.link      = LINK_NONE;
    req.live      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_SEARCH || op == OP_INSERT || op == OP_DELETE) begin
            state_next = S_HASH;
          end else begin
            // unused op code: plain not-found answer
            done_next     = 1'b1;
            status_next   = ST_NOT_FOUND;
            position_next = '0;
          end
        end
      end

      S_HASH: begin
        if (hres.valid) begin
          bucket_r_next = hres.bucket;
          idx_next      = head[hres.bucket];
          tail_next     = LINK_NONE;
          freed_next    = LINK_NONE;
          steps_next    = '0;
          state_next    = S_FETCH;
        end
      end

      S_FETCH: begin
        if (idx[LINK_W-1] || steps == USED_MAX) begin
          // end of chain
          state_next    = S_IDLE;
          done_next     = 1'b1;
          status_next   = ST_NOT_FOUND;
          position_next = '0;
          if (op_r == OP_INSERT) begin
            if (!freed[LINK_W-1]) begin
              // reuse the first freed record, link kept
              req.addr      = freed[IDX_W-1:0];
              req.we_key    = 1'b1;
              req.we_data   = 1'b1;
              req.we_live   = 1'b1;
              status_next   = ST_OK;
              position_next = to_pos(freed[IDX_W-1:0]);
            end else if (used == USED_MAX) begin
              status_next = ST_FULL;
            end else begin
              // append a fresh record, link it next cycle
              req.addr    = n_idx;
              req.we_key  = 1'b1;
              req.we_data = 1'b1;
              req.we_link = 1'b1;
              req.we_live = 1'b1;
              done_next   = 1'b0;
              state_next  = S_LINK;
            end
          end
        end else begin
          req.rd_en  = 1'b1;
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        if (match) begin
          state_next    = S_IDLE;
          done_next     = 1'b1;
          status_next   = ST_OK;
          position_next = to_pos(idx[IDX_W-1:0]);
          case (op_r)
            OP_INSERT: begin
              status_next   = ST_DUPLICATE;
              position_next = '0;
            end
            OP_DELETE: begin
              req.we_live = 1'b1;
              req.live    = 1'b0;
            end
            default: begin
            end
          endcase
        end else begin
          if (!rsp.live && freed[LINK_W-1]) begin
            freed_next = idx;
          end
          tail_next  = idx;
          idx_next   = rsp.link;
          steps_next = steps + CNT_W'(1);
          state_next = S_FETCH;
        end
      end

      S_LINK: begin
        if (tail[LINK_W-1]) begin
          head_we = 1'b1;
        end else begin
          req.addr    = tail[IDX_W-1:0];
          req.we_link = 1'b1;
          req.link    = {1'b0, n_idx};
        end
        used_next     = used + CNT_W'(1);
        state_next    = S_IDLE;
        done_next     = 1'b1;
        status_next   = ST_OK;
        position_next = to_pos(n_idx);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (position == '0))
    else $error("nonzero position on failed item");

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= USED_MAX)
    else $error("record count beyond store size");

  a_hash_in_walk: assert property (@(posedge clk) disable iff (rst)
    hres.valid |-> (state == S_HASH))
    else $error("bucket ready outside hash phase");

endmodule

@@ tb/chained_hash_table_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_test
// Drives search, insert and delete items into the hash table engine and
// checks every status and record position against an in-bench chained table.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_test;
  import cht_pkg::*;

  // op code that the engine answers with not-found
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // end of a chain in the mirror table
  localparam int CHAIN_END     = RECORDS;
  localparam int RANDOM_ITEMS  = 830;
  localparam int FILL_ITEMS    = 450;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
    int unsigned       gap;
  } cmd_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                start    = 1'b0;
  logic [OP_W-1:0]     op       = '0;
  logic [KEY_W-1:0]    key      = '0;
  logic [DATA_W-1:0]   payload  = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  chained_hash_table_engine dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .key      (key),
    .payload  (payload),
    .done     (done),
    .status   (status),
    .position (position)
  );

  // mirror of the table
  int                slot_head [BUCKETS];
  logic [KEY_W-1:0]  slot_key  [RECORDS];
  logic [DATA_W-1:0] slot_data [RECORDS];
  int                slot_link [RECORDS];
  bit                slot_live [RECORDS];
  int                slots_taken;

  cmd_t              pending_cmds[$];
  outcome_t          expected_outcomes[$];
  logic [KEY_W-1:0]  known_keys[$];
  cmd_t              staged_cmd;
  bit                staged_valid  = 1'b0;
  int unsigned       gap_left      = 0;
  bit                no_idle       = 1'b0;
  bit                item_taken    = 1'b0;
  int                items_accepted = 0;
  int                total_items   = 0;
  int                results_seen  = 0;
  int                mismatch_count = 0;
  int                idle_cycles   = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // first live record holding the key in a bucket's chain
  function automatic int chain_find(int b, logic [KEY_W-1:0] k);
    int idx;
    int steps;
    idx   = slot_head[b];
    steps = 0;
    while (idx < RECORDS && steps < RECORDS) begin
      if (slot_live[idx] && slot_key[idx] == k) return idx;
      idx = slot_link[idx];
      steps++;
    end
    return CHAIN_END;
  endfunction

  // insert: duplicate check over the whole chain, then freed-record reuse,
  // then append of the next unused record
  function automatic outcome_t chain_insert(int b, logic [KEY_W-1:0] k,
                                            logic [DATA_W-1:0] d);
    outcome_t res;
    int idx;
    int tail;
    int freed;
    int steps;
    res.status   = ST_OK;
    res.position = '0;
    idx   = slot_head[b];
    tail  = CHAIN_END;
    freed = CHAIN_END;
    steps = 0;
    while (idx < RECORDS && steps < RECORDS) begin
      if (slot_live[idx]) begin
        if (slot_key[idx] == k) begin
          res.status = ST_DUPLICATE;
          return res;
        end
      end else if (freed == CHAIN_END) begin
        freed = idx;
      end
      tail = idx;
      idx  = slot_link[idx];
      steps++;
    end
    if (freed != CHAIN_END) begin
      // reused record keeps its link
      slot_key[freed]  = k;
      slot_data[freed] = d;
      slot_live[freed] = 1'b1;
      res.position     = POS_W'(freed);
      return res;
    end
    if (slots_taken >= RECORDS) begin
      res.status = ST_FULL;
      return res;
    end
    slot_key[slots_taken]  = k;
    slot_data[slots_taken] = d;
    slot_link[slots_taken] = CHAIN_END;
    slot_live[slots_taken] = 1'b1;
    if (tail == CHAIN_END) slot_head[b] = slots_taken;
    else slot_link[tail] = slots_taken;
    res.position = POS_W'(slots_taken);
    slots_taken++;
    return res;
  endfunction

  // expected result of one item, updating the mirror
  function automatic outcome_t table_apply(logic [OP_W-1:0] code,
                                           logic [KEY_W-1:0] k,
                                           logic [DATA_W-1:0] d);
    outcome_t res;
    int b;
    int idx;
    b            = int'(k % BUCKETS);
    res.status   = ST_NOT_FOUND;
    res.position = '0;
    if (code == OP_SEARCH || code == OP_DELETE) begin
      idx = chain_find(b, k);
      if (idx < RECORDS) begin
        if (code == OP_DELETE) slot_live[idx] = 1'b0;
        res.status   = ST_OK;
        res.position = POS_W'(idx);
      end
    end else if (code == OP_INSERT) begin
      res = chain_insert(b, k, d);
    end
    return res;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] code, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] d);
    cmd_t c;
    c.op      = code;
    c.key     = k;
    c.payload = d;
    c.gap     = no_idle ? 0 : $urandom_range(0, 15);
    pending_cmds.push_back(c);
  endtask

  // driver: presents items at the falling edge, holds each until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (!staged_valid && pending_cmds.size() > 0) begin
        staged_cmd   = pending_cmds.pop_front();
        staged_valid = 1'b1;
        gap_left     = staged_cmd.gap;
      end
      if (staged_valid && gap_left == 0) begin
        start        <= 1'b1;
        op           <= staged_cmd.op;
        key          <= staged_cmd.key;
        payload      <= staged_cmd.payload;
        staged_valid = 1'b0;
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  // monitor: checks results, predicts accepted items
  always @(posedge clk) begin
    outcome_t want;
    item_taken = !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("result %0d with no item outstanding: status %0d position %0d",
                     results_seen, status, position);
          mismatch_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status !== want.status || position !== want.position) begin
            if (mismatch_count < REPORT_MAX)
              $display("result %0d: status exp %0d got %0d, position exp %0d got %0d",
                       results_seen, want.status, status, want.position, position);
            mismatch_count++;
          end
        end
      end
      if (item_taken) begin
        expected_outcomes.push_back(table_apply(op, key, payload));
        items_accepted++;
      end
      if (item_taken || done) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [OP_W-1:0]  code;
    logic [KEY_W-1:0] k;
    int               roll;
    int               fresh_pct;
    bit               fresh;
    for (int i = 0; i < BUCKETS; i++) slot_head[i] = CHAIN_END;
    for (int i = 0; i < RECORDS; i++) begin
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_link[i] = 0;
      slot_live[i] = 1'b0;
    end
    slots_taken = 0;

    // directed: empty table, chain building, freed-record reuse, extremes
    queue_cmd(OP_SEARCH, 31'd0, '0);
    queue_cmd(OP_DELETE, 31'd0, '0);
    queue_cmd(OP_UNUSED, 31'd0, '0);
    queue_cmd(OP_INSERT, 31'd0, '0);
    queue_cmd(OP_INSERT, 31'd7, '1);
    queue_cmd(OP_INSERT, 31'd14, 64'h0123_4567_89ab_cdef);
    queue_cmd(OP_INSERT, 31'd0, '1);
    queue_cmd(OP_SEARCH, 31'd7, '0);
    queue_cmd(OP_DELETE, 31'd0, '0);
    queue_cmd(OP_SEARCH, 31'd0, '0);
    // live key behind a freed record is still a duplicate
    queue_cmd(OP_INSERT, 31'd14, '0);
    queue_cmd(OP_INSERT, 31'd21, 64'hfedc_ba98_7654_3210);
    queue_cmd(OP_DELETE, 31'd7, '0);
    queue_cmd(OP_DELETE, 31'd14, '0);
    queue_cmd(OP_INSERT, 31'd7, '1);
    queue_cmd(OP_INSERT, '1, '1);
    queue_cmd(OP_SEARCH, '1, '0);
    queue_cmd(OP_UNUSED, '1, '1);
    queue_cmd(OP_DELETE, '1, '1);
    queue_cmd(OP_DELETE, '1, '0);
    queue_cmd(OP_INSERT, 31'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_cmd(OP_INSERT, 31'h2aaa_aaaa, 64'h5555_5555_5555_5555);
    queue_cmd(OP_SEARCH, 31'd21, '0);
    known_keys = '{31'd0, 31'd7, 31'd14, 31'd21, 31'h5555_5555, 31'h2aaa_aaaa};

    // random: insert-heavy fill for FILL_ITEMS items, then a mixed load
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (i < FILL_ITEMS) begin
        code = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_DELETE :
               (roll < 95) ? OP_SEARCH : OP_UNUSED;
        fresh_pct = (code == OP_INSERT) ? 90 : 20;
      end else begin
        code = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE :
               (roll < 95) ? OP_SEARCH : OP_UNUSED;
        fresh_pct = (code == OP_INSERT) ? 50 : 20;
      end
      fresh = ($urandom_range(0, 99) < fresh_pct);
      if (fresh) k = KEY_W'($urandom);
      else k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (fresh && code == OP_INSERT) known_keys.push_back(k);
      queue_cmd(code, k, {$urandom, $urandom});
    end
    total_items = pending_cmds.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < total_items || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
